/* rtl/isplit_pkg.sv */
package isplit_pkg;

  // Default depth of the cut-point table
  localparam int MAX_CUTS_DEF = 16;

  // Fixed field widths
  localparam int TimeW  = 32;
  localparam int WideW  = 33;
  localparam int CountW = 5;
  localparam int SlotW  = 4;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SPLIT = 1'b1;

  // Walk sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_ADD    = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_TAIL   = 5'b10000
  } state_t;

endpackage

/* rtl/interval_splitter_at_cut_points_core.sv */
// Interval splitter at cut points. A load item (func = 0) writes one 32-bit
// cut point into the cut table slot cut_index. A record item (func = 1)
// gives an interval [start_time, end_time] that is split at every used cut
// point (table entry plus cut_offset, kept 33 bits wide so it never wraps).
// Each piece comes out as one beat carrying the record id, the piece's start
// and end, its event flag (set only on the last piece), the number of cuts
// passed and a last_of_run mark. With num_cuts at zero a record yields no
// beat. num_cuts above MAX_CUTS is used as MAX_CUTS, and loads to slots past
// the table are dropped. Table slots must be loaded before a record reads
// them. A record item holds in_stall high while the walk runs, so no new
// item is taken until the record is done: each cut walked takes a table
// read, an offset add and a compare and emit, and a closing piece follows
// when the last cut falls inside the interval; an output stall holds the
// walk. The single table read port and the registered adder set the read,
// add and decide steps. num_cuts is written through the cfg channel, which
// is always ready; write it only while no record is being split.
module interval_splitter_at_cut_points_core #(
  parameter int MAX_CUTS = isplit_pkg::MAX_CUTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [isplit_pkg::CountW-1:0]        cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic [isplit_pkg::SlotW-1:0]         cut_index,
  input  logic signed [isplit_pkg::TimeW-1:0]  cut_value,
  input  logic signed [isplit_pkg::TimeW-1:0]  record_id,
  input  logic signed [isplit_pkg::TimeW-1:0]  start_time,
  input  logic signed [isplit_pkg::TimeW-1:0]  end_time,
  input  logic                                 event_flag,
  input  logic signed [isplit_pkg::TimeW-1:0]  cut_offset,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [isplit_pkg::TimeW-1:0]  piece_id,
  output logic signed [isplit_pkg::WideW-1:0]  piece_start,
  output logic signed [isplit_pkg::WideW-1:0]  piece_end,
  output logic                                 piece_event,
  output logic [isplit_pkg::CountW-1:0]        interval_index,
  output logic                                 last_of_run
);

  localparam int IdxW = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int TW   = isplit_pkg::TimeW;
  localparam int WW   = isplit_pkg::WideW;
  localparam int CW   = isplit_pkg::CountW;

  // Cut-point table: one write port for loads, one registered read port
  // addressed by the walk counter.
  logic [TW-1:0] cut_mem [MAX_CUTS];
  logic [TW-1:0] rd_data;
  logic [IdxW-1:0] rd_addr;

  isplit_pkg::state_t state, state_next;

  logic [CW-1:0] num_cuts;

  // Per-record working registers
  logic signed [TW-1:0] id_r;
  logic signed [WW-1:0] s_r;
  logic signed [WW-1:0] e_r;
  logic                 ev_r;
  logic signed [TW-1:0] off_r;
  logic [CW-1:0]        n_lat;
  logic [CW-1:0]        k, k_next;
  logic signed [WW-1:0] c_r;

  logic in_acc;
  logic load_acc;
  logic split_acc;
  logic [CW-1:0] n_eff;

  logic ge_end;
  logic before_start;
  logic final_cut;
  logic out_free;

  // Output load controls
  logic                 out_load;
  logic signed [WW-1:0] o_start;
  logic signed [WW-1:0] o_end;
  logic                 o_ev;
  logic [CW-1:0]        o_idx;
  logic                 o_last;
  logic                 s_take_c;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != isplit_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (func == isplit_pkg::FUNC_LOAD);
  assign split_acc = in_acc && (func == isplit_pkg::FUNC_SPLIT);

  // Clamp the cut count to the table depth
  assign n_eff = (int'(num_cuts) > MAX_CUTS) ? CW'(MAX_CUTS) : num_cuts;

  assign rd_addr = IdxW'(k);

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (load_acc && (int'(cut_index) < MAX_CUTS)) begin
      cut_mem[IdxW'(cut_index)] <= cut_value;
    end
    rd_data <= cut_mem[rd_addr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cuts <= '0;
    end else if (cfg_valid && cfg_ready) begin
      num_cuts <= cfg_data;
    end
  end

  // Compare the shifted cut against the current start and the record end
  assign ge_end       = (c_r >= e_r);
  assign before_start = (s_r > c_r);
  assign final_cut    = (k == (n_lat - CW'(1)));
  assign out_free     = !out_valid || !out_stall;

  // Sequencer: decide next state and which piece to emit
  always_comb begin
    state_next = state;
    k_next     = k;
    out_load   = 1'b0;
    s_take_c   = 1'b0;
    o_start    = s_r;
    o_end      = e_r;
    o_ev       = ev_r;
    o_idx      = k;
    o_last     = 1'b1;
    unique case (state)
      isplit_pkg::ST_IDLE: begin
        if (split_acc && (n_eff != '0)) begin
          state_next = isplit_pkg::ST_READ;
          k_next     = '0;
        end
      end
      isplit_pkg::ST_READ: begin
        state_next = isplit_pkg::ST_ADD;
      end
      isplit_pkg::ST_ADD: begin
        state_next = isplit_pkg::ST_DECIDE;
      end
      isplit_pkg::ST_DECIDE: begin
        priority if (ge_end) begin
          // cut at or past the end: close the record here
          if (out_free) begin
            out_load   = 1'b1;
            state_next = isplit_pkg::ST_IDLE;
          end
        end else if (before_start) begin
          if (final_cut) begin
            if (out_free) begin
              out_load   = 1'b1;
              o_idx      = n_lat;
              state_next = isplit_pkg::ST_IDLE;
            end
          end else begin
            // cut before the start: skip it
            k_next     = k + CW'(1);
            state_next = isplit_pkg::ST_READ;
          end
        end else begin
          // cut inside the interval: emit the leading piece, move the start
          if (out_free) begin
            out_load = 1'b1;
            o_end    = c_r;
            o_ev     = 1'b0;
            o_last   = 1'b0;
            s_take_c = 1'b1;
            if (final_cut) begin
              state_next = isplit_pkg::ST_TAIL;
            end else begin
              k_next     = k + CW'(1);
              state_next = isplit_pkg::ST_READ;
            end
          end
        end
      end
      isplit_pkg::ST_TAIL: begin
        // closing piece after the last cut
        if (out_free) begin
          out_load   = 1'b1;
          o_idx      = n_lat;
          state_next = isplit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = isplit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isplit_pkg::ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // Record registers: capture on accept, advance the start as cuts pass
  always_ff @(posedge clk) begin
    if (split_acc) begin
      id_r  <= record_id;
      s_r   <= {start_time[TW-1], start_time};
      e_r   <= {end_time[TW-1], end_time};
      ev_r  <= event_flag;
      off_r <= cut_offset;
      n_lat <= n_eff;
    end else if (s_take_c) begin
      s_r <= c_r;
    end
    if (state == isplit_pkg::ST_ADD) begin
      c_r <= signed'({rd_data[TW-1], rd_data}) + signed'({off_r[TW-1], off_r});
    end
  end

  // Output register: hold the beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      piece_id       <= id_r;
      piece_start    <= o_start;
      piece_end      <= o_end;
      piece_event    <= o_ev;
      interval_index <= o_idx;
      last_of_run    <= o_last;
    end
  end

  // A piece that does not close the record never carries the event
  a_event_only_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !piece_event)
    else $error("event flag on a non-final piece");

  // A leading piece never runs backward
  a_piece_order : assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> piece_start <= piece_end)
    else $error("leading piece ends before it starts");

  // The walk counter stays inside the used cuts while busy
  a_walk_bound : assert property (@(posedge clk) disable iff (rst)
    (state != isplit_pkg::ST_IDLE) |-> (k < n_lat))
    else $error("walk counter past the used cuts");

  // A split item with cuts in use starts the walk on the next cycle
  a_walk_start : assert property (@(posedge clk) disable iff (rst)
    split_acc && (n_eff != '0) |=> (state == isplit_pkg::ST_READ) && (k == '0))
    else $error("walk did not start after a split item");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_CUTS = isplit_pkg::MAX_CUTS_DEF;
  localparam int TimeW    = isplit_pkg::TimeW;
  localparam int WideW    = isplit_pkg::WideW;
  localparam int CountW   = isplit_pkg::CountW;
  localparam int SlotW    = isplit_pkg::SlotW;
  // Worst walk covers every cut plus the closing piece; pad it a little.
  localparam int SETTLE = 3 * MAX_CUTS + 8;
  // Slowest correct run is near 17 stalled beats per record; keep several times that.
  localparam int CYCLE_LIMIT = 500000;

  localparam logic signed [TimeW-1:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [TimeW-1:0] T_MAX = 32'sh7FFF_FFFF;

  // One input beat, load or record, with every field present.
  typedef struct {
    logic                     op;
    logic [SlotW-1:0]         slot;
    logic signed [TimeW-1:0]  cut;
    logic signed [TimeW-1:0]  rid;
    logic signed [TimeW-1:0]  t_start;
    logic signed [TimeW-1:0]  t_end;
    logic                     ev;
    logic signed [TimeW-1:0]  offset;
  } split_item_t;

  // One predicted piece of a split record.
  typedef struct {
    logic signed [TimeW-1:0]  pid;
    logic signed [WideW-1:0]  pstart;
    logic signed [WideW-1:0]  pend;
    logic                     pevent;
    logic [CountW-1:0]        pindex;
    logic                     plast;
  } piece_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CountW-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     func;
  logic [SlotW-1:0]         cut_index;
  logic signed [TimeW-1:0]  cut_value;
  logic signed [TimeW-1:0]  record_id;
  logic signed [TimeW-1:0]  start_time;
  logic signed [TimeW-1:0]  end_time;
  logic                     event_flag;
  logic signed [TimeW-1:0]  cut_offset;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TimeW-1:0]  piece_id;
  logic signed [WideW-1:0]  piece_start;
  logic signed [WideW-1:0]  piece_end;
  logic                     piece_event;
  logic [CountW-1:0]        interval_index;
  logic                     last_of_run;

  // Shadow copy of the cut table and the num_cuts register.
  logic signed [TimeW-1:0]  cut_slots [MAX_CUTS];
  logic [CountW-1:0]        cut_count;

  // Pieces predicted but not yet seen on the output, oldest first.
  piece_t pieces_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  interval_splitter_at_cut_points_core #(
    .MAX_CUTS(MAX_CUTS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .cut_index     (cut_index),
    .cut_value     (cut_value),
    .record_id     (record_id),
    .start_time    (start_time),
    .end_time      (end_time),
    .event_flag    (event_flag),
    .cut_offset    (cut_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .piece_id      (piece_id),
    .piece_start   (piece_start),
    .piece_end     (piece_end),
    .piece_event   (piece_event),
    .interval_index(interval_index),
    .last_of_run   (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: compare each accepted beat with the oldest predicted piece,
  // then pick the stall for the next cycle. Stalls come in random bursts while idle_on is set.
  always @(posedge clk) begin
    piece_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pieces_due.size() == 0) begin
        $error("unexpected piece: id %0d start %0d end %0d index %0d",
               piece_id, piece_start, piece_end, interval_index);
        mismatches++;
      end else begin
        want = pieces_due.pop_front();
        check_field("piece_id", 64'(want.pid), 64'(piece_id));
        check_field("piece_start", 64'(want.pstart), 64'(piece_start));
        check_field("piece_end", 64'(want.pend), 64'(piece_end));
        check_field("piece_event", 64'(want.pevent), 64'(piece_event));
        check_field("interval_index", 64'(want.pindex), 64'(interval_index));
        check_field("last_of_run", 64'(want.plast), 64'(last_of_run));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_piece(input logic signed [TimeW-1:0] rid,
                           input logic signed [WideW-1:0] s, input logic signed [WideW-1:0] e,
                           input logic ev, input logic [CountW-1:0] idx, input logic last);
    piece_t p;
    p.pid = rid;
    p.pstart = s;
    p.pend = e;
    p.pevent = ev;
    p.pindex = idx;
    p.plast = last;
    pieces_due = {pieces_due, p};
  endtask

  // Walk the used cuts in table order, shifted by the record's offset, and
  // queue the pieces the walk produces. The shifted cut is one bit wider so
  // it never wraps.
  task automatic predict_pieces(input split_item_t it);
    logic signed [WideW-1:0] lo;
    logic signed [WideW-1:0] cut_at;
    int used;
    int k;
    used = (int'(cut_count) > MAX_CUTS) ? MAX_CUTS : int'(cut_count);
    lo = WideW'(it.t_start);
    for (k = 0; k < used; k++) begin
      cut_at = WideW'(cut_slots[k]) + WideW'(it.offset);
      // Cut at or past the end closes the record.
      if (cut_at >= WideW'(it.t_end)) begin
        add_piece(it.rid, lo, WideW'(it.t_end), it.ev, CountW'(k), 1'b1);
        break;
      end
      // Cut inside the interval: emit an event-free piece, move the start.
      if (lo <= cut_at) begin
        add_piece(it.rid, lo, cut_at, 1'b0, CountW'(k), 1'b0);
        lo = cut_at;
      end
      // Past the last cut: the remainder is the closing piece.
      if (k == used - 1)
        add_piece(it.rid, lo, WideW'(it.t_end), it.ev, CountW'(used), 1'b1);
    end
  endtask

  function automatic split_item_t rand_item();
    split_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.slot = SlotW'($urandom_range(0, MAX_CUTS - 1));
    it.cut = $urandom;
    it.rid = $urandom;
    it.t_start = $urandom;
    it.t_end = $urandom;
    it.ev = 1'($urandom_range(0, 1));
    it.offset = $urandom;
    return it;
  endfunction

  // Drive one beat, optionally after an idle burst, and hold it until taken.
  // Valid stays high on return so a back-to-back caller keeps the stream full.
  task automatic send_item(input split_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= it.op;
    cut_index  <= it.slot;
    cut_value  <= it.cut;
    record_id  <= it.rid;
    start_time <= it.t_start;
    end_time   <= it.t_end;
    event_flag <= it.ev;
    cut_offset <= it.offset;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.op == isplit_pkg::FUNC_LOAD)
      cut_slots[it.slot] = it.cut;
    else
      predict_pieces(it);
  endtask

  task automatic load_cut(input logic [SlotW-1:0] slot, input logic signed [TimeW-1:0] value);
    split_item_t it;
    it = rand_item();
    it.op = isplit_pkg::FUNC_LOAD;
    it.slot = slot;
    it.cut = value;
    send_item(it);
  endtask

  task automatic send_record(input logic signed [TimeW-1:0] rid,
                             input logic signed [TimeW-1:0] s, input logic signed [TimeW-1:0] e,
                             input logic ev, input logic signed [TimeW-1:0] off);
    split_item_t it;
    it = rand_item();
    it.op = isplit_pkg::FUNC_SPLIT;
    it.rid = rid;
    it.t_start = s;
    it.t_end = e;
    it.ev = ev;
    it.offset = off;
    send_item(it);
  endtask

  // Drop valid, drain every predicted piece, then let a full walk's worth of
  // cycles pass in case the last beat caused no piece.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pieces_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_num_cuts(input logic [CountW-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cut_count = value;
  endtask

  // No cuts in use: records must produce nothing, both at reset and after
  // an explicit write of zero. Nothing is read from the still-empty table.
  task automatic test_zero_cuts();
    send_record(T_MIN, T_MIN, T_MAX, 1'b1, 0);
    write_num_cuts(5'd0);
    send_record(T_MAX, -100, 100, 1'b0, T_MAX);
  endtask

  // Four cuts, two at the extremes of the range: walk full spans, offsets that
  // push cuts past 32 bits, cuts on the start and on the end, a start past
  // the last cut and a start after the end.
  task automatic test_four_cut_walk();
    load_cut(4'd0, T_MIN);
    load_cut(4'd1, -5);
    load_cut(4'd2, 20);
    load_cut(4'd3, T_MAX);
    write_num_cuts(5'd4);
    send_record(T_MIN, T_MIN, T_MAX, 1'b1, 0);
    send_record(T_MAX, T_MIN, T_MAX, 1'b0, T_MIN);
    send_record(7, T_MIN, T_MAX, 1'b1, T_MAX);
    send_record(8, 0, 10, 1'b0, 0);
    send_record(9, 100, 200, 1'b1, 0);
    send_record(10, 50, -100, 1'b1, 0);
    send_record(11, -5, 100, 1'b0, 0);
    send_record(12, T_MAX, T_MAX, 1'b1, -10);
    send_record(13, -5, 20, 1'b1, 0);
  endtask

  // A single cut: a record past it gets only the closing piece, one starting on it a leading piece too.
  task automatic test_single_cut();
    write_num_cuts(5'd1);
    send_record(14, 0, 100, 1'b1, 0);
    send_record(15, T_MIN, 0, 1'b1, 0);
  endtask

  // Refill the whole table, then stream records. Most are built around the
  // shifted cuts so walks split many times; the rest are unconstrained
  // records and stray table rewrites.
  task automatic run_random_phase(input logic [CountW-1:0] ncuts, input int records,
                                  input bit ordered, input bit with_idle);
    split_item_t it;
    logic signed [TimeW-1:0] next_cut;
    longint a_at;
    longint b_at;
    longint swap;
    int used;
    int i;
    int k;
    write_num_cuts(ncuts);
    idle_on = with_idle;
    next_cut = $signed($urandom) >>> 2;
    for (k = 0; k < MAX_CUTS; k++) begin
      it = rand_item();
      it.op = isplit_pkg::FUNC_LOAD;
      it.slot = SlotW'(k);
      if (ordered) begin
        it.cut = next_cut;
        next_cut = next_cut + $urandom_range(0, 400);
      end
      send_item(it);
    end
    used = (int'(ncuts) > MAX_CUTS) ? MAX_CUTS : int'(ncuts);
    for (i = 0; i < records; i++) begin
      it = rand_item();
      case ($urandom_range(0, 9))
        0: it.op = isplit_pkg::FUNC_LOAD;
        1: it.op = isplit_pkg::FUNC_SPLIT;
        default: begin
          it.op = isplit_pkg::FUNC_SPLIT;
          it.offset = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 200)) - 100;
          a_at = longint'(cut_slots[$urandom_range(0, used - 1)]) + it.offset
                 + int'($urandom_range(0, 6)) - 3;
          b_at = longint'(cut_slots[$urandom_range(0, used - 1)]) + it.offset
                 + int'($urandom_range(0, 6)) - 3;
          // Mostly keep start at or before end.
          if (a_at > b_at && $urandom_range(0, 9) != 0) begin
            swap = a_at;
            a_at = b_at;
            b_at = swap;
          end
          it.t_start = a_at[TimeW-1:0];
          it.t_end = b_at[TimeW-1:0];
        end
      endcase
      send_item(it);
      // Hold off now and then until the output has fully drained.
      if ($urandom_range(0, 49) == 0)
        wait_idle();
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(5'd16, 40, 1'b1, 1'b1);
    run_random_phase(5'd1, 30, 1'b1, 1'b1);
    run_random_phase(5'd31, 40, 1'b0, 1'b1);
    run_random_phase(5'd17, 40, 1'b1, 1'b0);
    run_random_phase(CountW'($urandom_range(2, 15)), 40, 1'b1, 1'b1);
    run_random_phase(CountW'($urandom_range(2, 15)), 40, 1'b1, 1'b1);
    run_random_phase(5'd16, 40, 1'b0, 1'b1);
    // Close with full-rate traffic on both sides.
    run_random_phase(5'd16, 40, 1'b1, 1'b0);
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= isplit_pkg::FUNC_LOAD;
    cut_index  <= '0;
    cut_value  <= '0;
    record_id  <= '0;
    start_time <= '0;
    end_time   <= '0;
    event_flag <= 1'b0;
    cut_offset <= '0;
    cut_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_zero_cuts();
    test_four_cut_walk();
    test_single_cut();
    test_random_phases();

    wait_idle();
    if (mismatches == 0 && pieces_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
